FILE: rtl/core/mhu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mhu_pkg
// shared widths, codes and the whole-degree sine table for the heading unit
// ----------------------------------------------------------------------------
package mhu_pkg;

    // stream field widths
    localparam int READING_W  = 13;
    localparam int OFFSET_W   = 12;
    localparam int DECL_W     = 9;
    localparam int HEADING_W  = 9;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 16;

    // configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam logic [1:0] REG_OFFSET_X    = 2'd0;
    localparam logic [1:0] REG_OFFSET_Y    = 2'd1;
    localparam logic [1:0] REG_DECLINATION = 2'd2;

    // datapath widths
    localparam int DIFF_W  = READING_W + 1;   // reading minus offset
    localparam int MAG_W   = READING_W;       // folded magnitude, at most 6143
    localparam int SIN_W   = 49;              // sine in q48, up to 1.0
    localparam int PROD_W  = MAG_W + SIN_W;
    localparam int LO_W    = 7;               // degree within a quadrant
    localparam int SEARCH_STEPS = 7;
    localparam int ANGLE_W = 9;
    localparam int SUM_W   = 10;

    localparam logic [LO_W-1:0]    MAX_QUAD_DEG = 7'd89;
    localparam logic [LO_W-1:0]    RIGHT_ANGLE  = 7'd90;
    localparam logic [SUM_W-1:0]   FULL_TURN    = 10'd360;

    // quadrant codes and their base angles
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;
    localparam logic [ANGLE_W-1:0] BASE_Q1 = 9'd90;
    localparam logic [ANGLE_W-1:0] BASE_Q2 = 9'd180;
    localparam logic [ANGLE_W-1:0] BASE_Q3 = 9'd270;

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

    typedef logic [90:0][SIN_W-1:0] sin_tbl_t;

    // (a * b) >> 56, low 64 bits kept
    function automatic logic [63:0] mul_q56(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[119:56];
    endfunction

    // taylor series of sin(k degrees) in q56, rounded to q48
    function automatic sin_tbl_t build_sin_tbl();
        sin_tbl_t    tbl;
        logic [63:0] step;
        logic [63:0] th;
        logic [63:0] th2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] rnd;
        step = PI_Q60 / 180;
        for (int k = 0; k <= 90; k++) begin
            th  = (step * 64'(k)) >> 4;
            th2 = mul_q56(th, th);
            t   = th;
            s   = th;
            for (int n = 1; n < 20; n++) begin
                t = mul_q56(t, th2);
                case (n)
                    1:  t = t / 6;
                    2:  t = t / 20;
                    3:  t = t / 42;
                    4:  t = t / 72;
                    5:  t = t / 110;
                    6:  t = t / 156;
                    7:  t = t / 210;
                    8:  t = t / 272;
                    9:  t = t / 342;
                    10: t = t / 420;
                    11: t = t / 506;
                    12: t = t / 600;
                    13: t = t / 702;
                    14: t = t / 812;
                    15: t = t / 930;
                    16: t = t / 1056;
                    17: t = t / 1190;
                    18: t = t / 1332;
                    19: t = t / 1482;
                    default: t = t;
                endcase
                if (n[0]) begin
                    s = s - t;
                end else begin
                    s = s + t;
                end
            end
            rnd    = (s + 64'd128) >> 8;
            tbl[k] = rnd[SIN_W-1:0];
        end
        return tbl;
    endfunction

    localparam sin_tbl_t SIN_TBL = build_sin_tbl();

endpackage
`default_nettype wire

FILE: rtl/core/magnetometer_heading_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// magnetometer_heading_unit
// compass heading in whole degrees from one offset-corrected x/y sample
// ----------------------------------------------------------------------------
// pipeline: 17 stages, the difference, the quadrant fold, the seven-step
//   search of the whole-degree sine table, each step a multiply stage and
//   a compare stage, and the output register
// throughput: one transaction per cycle, held back only by m_tready
// reset: aresetn synchronous, active low; empties the pipeline and loads
//   offset_x 55, offset_y -130, declination 4
// ----------------------------------------------------------------------------
module magnetometer_heading_unit (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // input stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [12:0] x_reading, [25:13] y_reading, [31:26] zero
    input  wire logic [mhu_pkg::S_TDATA_W-1:0]       s_tdata,
    // result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [8:0] heading_deg, [15:9] zero
    output logic [mhu_pkg::M_TDATA_W-1:0]            m_tdata,
    // configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [mhu_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [mhu_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [mhu_pkg::APB_DATA_W-1:0]           prdata,
    output logic                                     pready
);

    // stage map: 0 difference, 1 quadrant fold, 2+2j multiply of step j,
    // 3+2j compare of step j, last stage is the output register
    localparam int NSTAGE = 2 + 2 * mhu_pkg::SEARCH_STEPS + 1;
    localparam int NS     = mhu_pkg::SEARCH_STEPS;

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    logic signed [mhu_pkg::OFFSET_W-1:0] offset_x_reg;
    logic signed [mhu_pkg::OFFSET_W-1:0] offset_y_reg;
    logic        [mhu_pkg::DECL_W-1:0]   decl_reg;
    logic                                cfg_wr;
    logic [1:0]                          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_x_reg <= 12'sd55;
            offset_y_reg <= -12'sd130;
            decl_reg     <= 9'd4;
        end else if (cfg_wr) begin
            case (cfg_idx)
                mhu_pkg::REG_OFFSET_X:    offset_x_reg <= pwdata[mhu_pkg::OFFSET_W-1:0];
                mhu_pkg::REG_OFFSET_Y:    offset_y_reg <= pwdata[mhu_pkg::OFFSET_W-1:0];
                mhu_pkg::REG_DECLINATION: decl_reg     <= pwdata[mhu_pkg::DECL_W-1:0];
                default: ;
            endcase
        end
    end

    // offsets read back sign-extended
    always_comb begin
        case (cfg_idx)
            mhu_pkg::REG_OFFSET_X:    prdata = 32'(offset_x_reg);
            mhu_pkg::REG_OFFSET_Y:    prdata = 32'(offset_y_reg);
            mhu_pkg::REG_DECLINATION: prdata = 32'(decl_reg);
            default:                  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // pipeline flow control: a stage loads when it is empty or drains
    // ------------------------------------------------------------------------
    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] stage_en;

    always_comb begin
        stage_en[NSTAGE-1] = !vld_reg[NSTAGE-1] || m_tready;
        for (int i = NSTAGE - 2; i >= 0; i--) begin
            stage_en[i] = !vld_reg[i] || stage_en[i+1];
        end
    end

    assign s_tready = stage_en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (stage_en[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NSTAGE; i++) begin
                if (stage_en[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stage 0: remove hard-iron offsets
    // ------------------------------------------------------------------------
    logic signed [mhu_pkg::READING_W-1:0] x_in;
    logic signed [mhu_pkg::READING_W-1:0] y_in;
    logic signed [mhu_pkg::DIFF_W-1:0]    dx_reg;
    logic signed [mhu_pkg::DIFF_W-1:0]    dy_reg;
    logic signed [mhu_pkg::DIFF_W-1:0]    dx_next;
    logic signed [mhu_pkg::DIFF_W-1:0]    dy_next;

    assign x_in    = s_tdata[12:0];
    assign y_in    = s_tdata[25:13];
    assign dx_next = mhu_pkg::DIFF_W'(x_in) - mhu_pkg::DIFF_W'(offset_x_reg);
    assign dy_next = mhu_pkg::DIFF_W'(y_in) - mhu_pkg::DIFF_W'(offset_y_reg);

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
    end

    // ------------------------------------------------------------------------
    // stage 1: fold the vector into the first quadrant, rx > 0 and ry >= 0
    // ------------------------------------------------------------------------
    logic [1:0]                 q_reg, q_next;
    logic [mhu_pkg::MAG_W-1:0]  rx_reg, rx_next;
    logic [mhu_pkg::MAG_W-1:0]  ry_reg, ry_next;
    logic                       zero_reg, zero_next;
    logic [mhu_pkg::DIFF_W-1:0] ndx;
    logic [mhu_pkg::DIFF_W-1:0] ndy;

    assign ndx = -dx_reg;
    assign ndy = -dy_reg;

    always_comb begin
        zero_next = (dx_reg == '0) && (dy_reg == '0);
        if (dx_reg > 0 && dy_reg >= 0) begin
            q_next  = mhu_pkg::QUAD_0;
            rx_next = dx_reg[mhu_pkg::MAG_W-1:0];
            ry_next = dy_reg[mhu_pkg::MAG_W-1:0];
        end else if (dx_reg <= 0 && dy_reg > 0) begin
            q_next  = mhu_pkg::QUAD_1;
            rx_next = dy_reg[mhu_pkg::MAG_W-1:0];
            ry_next = ndx[mhu_pkg::MAG_W-1:0];
        end else if (dx_reg < 0 && dy_reg <= 0) begin
            q_next  = mhu_pkg::QUAD_2;
            rx_next = ndx[mhu_pkg::MAG_W-1:0];
            ry_next = ndy[mhu_pkg::MAG_W-1:0];
        end else begin
            // also the zero vector, overridden at the end
            q_next  = mhu_pkg::QUAD_3;
            rx_next = ndy[mhu_pkg::MAG_W-1:0];
            ry_next = dx_reg[mhu_pkg::MAG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            q_reg    <= q_next;
            rx_reg   <= rx_next;
            ry_reg   <= ry_next;
            zero_reg <= zero_next;
        end
    end

    // ------------------------------------------------------------------------
    // stages 2..15: binary search for the largest k in 0..89 with
    // ry*sin(90-k) >= rx*sin(k); the test falls monotonically in k, so the
    // degree is built one bit a step from the top bit down
    // ------------------------------------------------------------------------
    // inputs of each multiply stage
    logic [1:0]                src_q    [NS];
    logic [mhu_pkg::MAG_W-1:0] src_rx   [NS];
    logic [mhu_pkg::MAG_W-1:0] src_ry   [NS];
    logic                      src_zero [NS];
    logic [mhu_pkg::LO_W-1:0]  src_lo   [NS];

    // multiply stage registers
    logic [1:0]                 mq_reg    [NS];
    logic [mhu_pkg::MAG_W-1:0]  mrx_reg   [NS];
    logic [mhu_pkg::MAG_W-1:0]  mry_reg   [NS];
    logic                       mzero_reg [NS];
    logic [mhu_pkg::LO_W-1:0]   mlo_reg   [NS];
    logic [mhu_pkg::LO_W-1:0]   mcand_reg [NS];
    logic                       mok_reg   [NS];
    logic [mhu_pkg::PROD_W-1:0] mpa_reg   [NS];
    logic [mhu_pkg::PROD_W-1:0] mpb_reg   [NS];

    logic [mhu_pkg::LO_W-1:0]   cand_next [NS];
    logic                       ok_next   [NS];
    logic [mhu_pkg::LO_W-1:0]   sidx      [NS];
    logic [mhu_pkg::LO_W-1:0]   cidx      [NS];
    logic [mhu_pkg::PROD_W-1:0] pa_next   [NS];
    logic [mhu_pkg::PROD_W-1:0] pb_next   [NS];

    // compare stage registers
    logic [1:0]                 cq_reg    [NS];
    logic [mhu_pkg::MAG_W-1:0]  crx_reg   [NS];
    logic [mhu_pkg::MAG_W-1:0]  cry_reg   [NS];
    logic                       czero_reg [NS];
    logic [mhu_pkg::LO_W-1:0]   clo_reg   [NS];
    logic [mhu_pkg::LO_W-1:0]   clo_next  [NS];

    always_comb begin
        src_q[0]    = q_reg;
        src_rx[0]   = rx_reg;
        src_ry[0]   = ry_reg;
        src_zero[0] = zero_reg;
        src_lo[0]   = '0;
        for (int j = 1; j < NS; j++) begin
            src_q[j]    = cq_reg[j-1];
            src_rx[j]   = crx_reg[j-1];
            src_ry[j]   = cry_reg[j-1];
            src_zero[j] = czero_reg[j-1];
            src_lo[j]   = clo_reg[j-1];
        end
    end

    // candidate degree and the two cross products
    always_comb begin
        for (int j = 0; j < NS; j++) begin
            cand_next[j] = src_lo[j] | mhu_pkg::LO_W'(1 << (NS - 1 - j));
            ok_next[j]   = cand_next[j] <= mhu_pkg::MAX_QUAD_DEG;
            sidx[j]      = ok_next[j] ? cand_next[j] : '0;
            cidx[j]      = ok_next[j] ? (mhu_pkg::RIGHT_ANGLE - cand_next[j]) : '0;
            pa_next[j]   = mhu_pkg::PROD_W'(src_ry[j])
                         * mhu_pkg::PROD_W'(mhu_pkg::SIN_TBL[cidx[j]]);
            pb_next[j]   = mhu_pkg::PROD_W'(src_rx[j])
                         * mhu_pkg::PROD_W'(mhu_pkg::SIN_TBL[sidx[j]]);
        end
    end

    // keep the candidate where the angle still reaches it
    always_comb begin
        for (int j = 0; j < NS; j++) begin
            clo_next[j] = (mok_reg[j] && (mpa_reg[j] >= mpb_reg[j])) ? mcand_reg[j]
                                                                     : mlo_reg[j];
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < NS; j++) begin
            if (stage_en[2 + 2 * j]) begin
                mq_reg[j]    <= src_q[j];
                mrx_reg[j]   <= src_rx[j];
                mry_reg[j]   <= src_ry[j];
                mzero_reg[j] <= src_zero[j];
                mlo_reg[j]   <= src_lo[j];
                mcand_reg[j] <= cand_next[j];
                mok_reg[j]   <= ok_next[j];
                mpa_reg[j]   <= pa_next[j];
                mpb_reg[j]   <= pb_next[j];
            end
            if (stage_en[3 + 2 * j]) begin
                cq_reg[j]    <= mq_reg[j];
                crx_reg[j]   <= mrx_reg[j];
                cry_reg[j]   <= mry_reg[j];
                czero_reg[j] <= mzero_reg[j];
                clo_reg[j]   <= clo_next[j];
            end
        end
    end

    // ------------------------------------------------------------------------
    // last stage: quadrant base, declination and a single wrap
    // ------------------------------------------------------------------------
    logic [mhu_pkg::ANGLE_W-1:0]   base_deg;
    logic [mhu_pkg::ANGLE_W-1:0]   angle_deg;
    logic [mhu_pkg::SUM_W-1:0]     sum_deg;
    logic [mhu_pkg::SUM_W-1:0]     wrap_deg;
    logic [mhu_pkg::HEADING_W-1:0] heading_reg;

    always_comb begin
        case (cq_reg[NS-1])
            mhu_pkg::QUAD_0: base_deg = '0;
            mhu_pkg::QUAD_1: base_deg = mhu_pkg::BASE_Q1;
            mhu_pkg::QUAD_2: base_deg = mhu_pkg::BASE_Q2;
            mhu_pkg::QUAD_3: base_deg = mhu_pkg::BASE_Q3;
            default:         base_deg = '0;
        endcase
        // the zero vector points at 0 degrees
        angle_deg = czero_reg[NS-1] ? '0
                  : base_deg + mhu_pkg::ANGLE_W'(clo_reg[NS-1]);
        sum_deg   = mhu_pkg::SUM_W'(angle_deg) + mhu_pkg::SUM_W'(decl_reg);
        // exactly 360 is kept
        wrap_deg  = (sum_deg > mhu_pkg::FULL_TURN) ? (sum_deg - mhu_pkg::FULL_TURN) : sum_deg;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[NSTAGE-1]) begin
            heading_reg <= wrap_deg[mhu_pkg::HEADING_W-1:0];
        end
    end

    assign m_tvalid = vld_reg[NSTAGE-1];
    assign m_tdata  = mhu_pkg::M_TDATA_W'(heading_reg);

endmodule
`default_nettype wire
